[hdl/niu_pkg.sv]
// ----------------------------------------------------------------------------
// niu_pkg
// shared constants and types of the newton interpolation unit
// ----------------------------------------------------------------------------
`default_nettype none
package niu_pkg;
    localparam int MAX_POINTS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 4;
    localparam logic [CNT_W-1:0] NUM_POINTS_RESET = CNT_W'(6);
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_DIVST = 3'd2;
    localparam logic [2:0] OP_DIVWB = 3'd3;
    localparam logic [2:0] OP_HINIT = 3'd4;
    localparam logic [2:0] OP_HSUB  = 3'd5;
    localparam logic [2:0] OP_HMUL  = 3'd6;
    localparam logic [2:0] OP_HADD  = 3'd7;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx_a;   // coeff/node index i
        logic [IDX_W-1:0] idx_b;   // index i-j for node
        logic             div_step;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;
endpackage
`default_nettype wire

[hdl/niu_if.sv]
// ----------------------------------------------------------------------------
// niu_req_if / niu_rsp_if / niu_cfg_if
// valid/ready channels of the newton interpolation unit
// ----------------------------------------------------------------------------
`default_nettype none
interface niu_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic signed [31:0] node_position;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_point;
    modport source (output valid, req_type, node_position, sample_value, query_point,
                    input ready);
    modport sink (input valid, req_type, node_position, sample_value, query_point,
                  output ready);
    modport monitor (input valid, ready, req_type, node_position, sample_value,
                     query_point);
endinterface

interface niu_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] poly_value;
    logic        error_flag;
    modport source (output valid, poly_value, error_flag, input ready);
    modport sink (input valid, poly_value, error_flag, output ready);
    modport monitor (input valid, ready, poly_value, error_flag);
endinterface

interface niu_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
    modport monitor (input valid, ready, data);
endinterface
`default_nettype wire

[hdl/niu_datapath.sv]
// ----------------------------------------------------------------------------
// niu_datapath
// node and coefficient stores, bit-serial divider, horner multiply-add
// ----------------------------------------------------------------------------
`default_nettype none
module niu_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire niu_pkg::cmd_t         cmd,
    input  wire logic signed [31:0]    node_in,
    input  wire logic signed [31:0]    sample_in,
    input  wire logic signed [31:0]    query_in,
    output niu_pkg::stat_t             stat,
    output logic signed [31:0]         result,
    output logic                       ovf_flag,
    output logic                       bad_flag
);
    localparam int QW = 32 + niu_pkg::FRAC_BITS + 2;

    logic signed [31:0] node_mem [niu_pkg::MAX_POINTS];
    logic signed [31:0] coeff_mem [niu_pkg::MAX_POINTS];

    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [31:0] qry_reg;
    logic signed [63:0] prod_reg;
    logic ovf_reg, ovf_next;
    logic bad_reg, bad_next;

    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [32:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [6:0]    cnt_reg, cnt_next;

    logic signed [32:0] dnode, dcoef;
    logic [32:0] mag_num, mag_den;
    logic [QW-1:0] trial;
    logic [QW-1:0] qsat;
    logic signed [33:0] qs;
    logic signed [32:0] hsub;
    logic [63:0] pmag;
    logic signed [33:0] hsum;

    always_comb
    begin
        dnode   = 33'(node_mem[cmd.idx_a]) - 33'(node_mem[cmd.idx_b]);
        dcoef   = 33'(coeff_mem[cmd.idx_a])
                  - 33'(coeff_mem[cmd.idx_a - niu_pkg::IDX_W'(1)]);
        mag_num = dcoef[32] ? 33'(-dcoef) : 33'(dcoef);
        mag_den = dnode[32] ? 33'(-dnode) : 33'(dnode);
        trial   = {rem_reg[QW-2:0], quo_reg[QW-1]};
        qsat    = (quo_reg > (QW'(1) << 32)) ? (QW'(1) << 32) : quo_reg;
        qs      = neg_reg ? -34'(qsat) : 34'(qsat);
        hsub    = 33'(qry_reg) - 33'(node_mem[cmd.idx_a]);
        pmag    = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        pmag    = pmag >> niu_pkg::FRAC_BITS;
        hsum    = 34'(prod_reg[63] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag}))
                  + 34'(coeff_mem[cmd.idx_a]);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        diff_next = diff_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        if (cnt_reg != 7'd0)
        begin
            if (trial >= QW'(den_reg))
            begin
                rem_next = trial - QW'(den_reg);
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
        case (cmd.op)
            niu_pkg::OP_LOAD:
            begin
                if (cmd.div_step)
                    bad_next = 1'b0;
            end
            niu_pkg::OP_DIVST:
            begin
                rem_next = '0;
                quo_next = QW'(mag_num) << niu_pkg::FRAC_BITS;
                den_next = mag_den;
                neg_next = dcoef[32] != dnode[32];
                cnt_next = 7'(QW);
            end
            niu_pkg::OP_HINIT:
            begin
                acc_next = coeff_mem[cmd.idx_a];
                ovf_next = 1'b0;
            end
            niu_pkg::OP_HSUB:
            begin
                if (hsub > 33'sd2147483647)
                begin
                    diff_next = 32'sh7fffffff;
                    ovf_next = 1'b1;
                end
                else if (hsub < -33'sd2147483648)
                begin
                    diff_next = 32'sh80000000;
                    ovf_next = 1'b1;
                end
                else
                    diff_next = 32'(hsub);
            end
            niu_pkg::OP_HADD:
            begin
                if (pmag > 64'hffffffff && !prod_reg[63])
                begin
                    acc_next = 32'sh7fffffff;
                    ovf_next = 1'b1;
                end
                else if (prod_reg[63] && pmag > 64'h80000000 + 64'h7fffffff)
                begin
                    acc_next = 32'sh80000000;
                    ovf_next = 1'b1;
                end
                else if (hsum > 34'sd2147483647)
                begin
                    acc_next = 32'sh7fffffff;
                    ovf_next = 1'b1;
                end
                else if (hsum < -34'sd2147483648)
                begin
                    acc_next = 32'sh80000000;
                    ovf_next = 1'b1;
                end
                else
                    acc_next = 32'(hsum);
            end
            default:
            begin
            end
        endcase
        if (cmd.op == niu_pkg::OP_DIVWB)
        begin
            if (den_reg == 33'd0 || qs > 34'sd2147483647 || qs < -34'sd2147483648)
                bad_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            bad_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            bad_reg <= bad_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        if (cmd.op == niu_pkg::OP_HINIT)
            qry_reg <= query_in;
        if (cmd.op == niu_pkg::OP_HMUL)
            prod_reg <= 64'(acc_reg) * 64'(diff_reg);
        if (cmd.op == niu_pkg::OP_LOAD)
        begin
            node_mem[cmd.idx_a]  <= node_in;
            coeff_mem[cmd.idx_a] <= sample_in;
        end
        if (cmd.op == niu_pkg::OP_DIVWB)
        begin
            if (den_reg == 33'd0)
                coeff_mem[cmd.idx_a] <= '0;
            else if (qs > 34'sd2147483647)
                coeff_mem[cmd.idx_a] <= 32'sh7fffffff;
            else if (qs < -34'sd2147483648)
                coeff_mem[cmd.idx_a] <= 32'sh80000000;
            else
                coeff_mem[cmd.idx_a] <= 32'(qs);
        end
    end

    assign stat.div_busy = cnt_reg != 7'd0;
    assign result   = acc_reg;
    assign ovf_flag = ovf_reg;
    assign bad_flag = bad_reg;
endmodule
`default_nettype wire

[hdl/niu_control.sv]
// ----------------------------------------------------------------------------
// niu_control
// sequencer for load, coefficient build and horner evaluation
// ----------------------------------------------------------------------------
`default_nettype none
module niu_control (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire logic                           req_type,
    input  wire logic                           cfg_valid,
    input  wire logic [niu_pkg::CNT_W-1:0]      cfg_data,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output logic                                rsp_zero,
    output niu_pkg::cmd_t                       cmd,
    input  wire niu_pkg::stat_t                 stat
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVST = 3'd1;
    localparam logic [2:0] S_DIVWT = 3'd2;
    localparam logic [2:0] S_HSUB  = 3'd3;
    localparam logic [2:0] S_HMUL  = 3'd4;
    localparam logic [2:0] S_HADD  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    localparam int IW = niu_pkg::IDX_W;

    logic [2:0] state_reg, state_next;
    logic [niu_pkg::CNT_W-1:0] np_reg, np_next;
    logic [niu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic ready_flag_reg, ready_flag_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic zero_reg, zero_next;
    logic [niu_pkg::CNT_W-1:0] n_eff;
    logic [IW-1:0] nm1;
    logic [niu_pkg::CNT_W-1:0] lc;
    logic accept;

    always_comb
    begin
        if (np_reg < niu_pkg::CNT_W'(2))
            n_eff = niu_pkg::CNT_W'(2);
        else if (np_reg > niu_pkg::CNT_W'(niu_pkg::MAX_POINTS))
            n_eff = niu_pkg::CNT_W'(niu_pkg::MAX_POINTS);
        else
            n_eff = np_reg;
        nm1 = IW'(n_eff - niu_pkg::CNT_W'(1));
        lc  = (cnt_reg >= n_eff) ? '0 : cnt_reg;
    end

    assign req_ready = state_reg == S_IDLE;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = state_reg == S_RESP;
    assign rsp_zero  = zero_reg;

    always_comb
    begin
        state_next      = state_reg;
        np_next         = np_reg;
        cnt_next        = cnt_reg;
        ready_flag_next = ready_flag_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        zero_next       = zero_reg;
        cmd             = '0;
        cmd.idx_a       = i_reg;
        cmd.idx_b       = IW'(i_reg - j_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    np_next = cfg_data;
                    cnt_next = '0;
                    ready_flag_next = 1'b0;
                end
                else if (accept && req_type == niu_pkg::REQ_LOAD)
                begin
                    cmd.op = niu_pkg::OP_LOAD;
                    cmd.idx_a = IW'(lc);
                    cmd.div_step = lc == '0;
                    if (lc == '0)
                        ready_flag_next = 1'b0;
                    if (lc + niu_pkg::CNT_W'(1) >= n_eff)
                    begin
                        cnt_next = '0;
                        j_next = IW'(1);
                        i_next = nm1;
                        state_next = S_DIVST;
                    end
                    else
                        cnt_next = lc + niu_pkg::CNT_W'(1);
                end
                else if (accept)
                begin
                    if (!ready_flag_reg)
                    begin
                        zero_next = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        cmd.op = niu_pkg::OP_HINIT;
                        cmd.idx_a = nm1;
                        i_next = nm1 - IW'(1);
                        state_next = S_HSUB;
                    end
                end
            end
            S_DIVST:
            begin
                cmd.op = niu_pkg::OP_DIVST;
                state_next = S_DIVWT;
            end
            S_DIVWT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = niu_pkg::OP_DIVWB;
                    if (i_reg > j_reg)
                    begin
                        i_next = i_reg - IW'(1);
                        state_next = S_DIVST;
                    end
                    else if (j_reg < nm1)
                    begin
                        j_next = j_reg + IW'(1);
                        i_next = nm1;
                        state_next = S_DIVST;
                    end
                    else
                    begin
                        ready_flag_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_HSUB:
            begin
                cmd.op = niu_pkg::OP_HSUB;
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.op = niu_pkg::OP_HMUL;
                state_next = S_HADD;
            end
            S_HADD:
            begin
                cmd.op = niu_pkg::OP_HADD;
                if (i_reg == '0)
                    state_next = S_RESP;
                else
                begin
                    i_next = i_reg - IW'(1);
                    state_next = S_HSUB;
                end
            end
            S_RESP:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            np_reg         <= niu_pkg::NUM_POINTS_RESET;
            cnt_reg        <= '0;
            ready_flag_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            zero_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            np_reg         <= np_next;
            cnt_reg        <= cnt_next;
            ready_flag_reg <= ready_flag_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            zero_reg       <= zero_next;
        end
    end
endmodule
`default_nettype wire

[hdl/newton_interpolation_unit.sv]
// ----------------------------------------------------------------------------
// newton_interpolation_unit
// newton divided-difference interpolation in signed q16.16
// ----------------------------------------------------------------------------
// One item at a time. The load that completes a set then builds the
// coefficients with n*(n-1)/2 divisions through a shared bit-serial divider.
// An evaluate runs n-1 horner steps (subtract, multiply, add), then waits in
// the output register until the result beat is taken. Configuration writes are
// taken while idle and no request is valid.
`default_nettype none
module newton_interpolation_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    niu_req_if.sink    req,
    niu_rsp_if.source  rsp,
    niu_cfg_if.sink    cfg
);
    niu_pkg::cmd_t  cmd;
    niu_pkg::stat_t stat;
    logic signed [31:0] result;
    logic ovf_flag, bad_flag, rsp_zero;

    assign cfg.ready = req.ready && !req.valid;

    niu_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_type  (req.req_type),
        .cfg_valid (cfg.valid && cfg.ready),
        .cfg_data  (cfg.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_zero  (rsp_zero),
        .cmd       (cmd),
        .stat      (stat)
    );

    niu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .node_in   (req.node_position),
        .sample_in (req.sample_value),
        .query_in  (req.query_point),
        .stat      (stat),
        .result    (result),
        .ovf_flag  (ovf_flag),
        .bad_flag  (bad_flag)
    );

    assign rsp.poly_value = rsp_zero ? 32'sd0 : result;
    assign rsp.error_flag = rsp_zero | ovf_flag | bad_flag;
endmodule
`default_nettype wire
